FILE: rtl/core/xdfl_pkg.sv
// Shared types and constants of the X.509 DER field locator.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package xdfl_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_CAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ISSUER_CAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBJECT_CAP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS_ONLY = 2'd3;

    localparam logic [1:0] KIND_SERIAL  = 2'd0;
    localparam logic [1:0] KIND_ISSUER  = 2'd1;
    localparam logic [1:0] KIND_SUBJECT = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_HEADER    = 2'd1;
    localparam logic [1:0] ST_CAPACITY  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam logic [7:0] TAG_HIGH_MASK = 8'h1F;
    localparam logic [7:0] LEN_INDEF     = 8'h80;
    localparam logic [7:0] LEN_LONG_MAX  = 8'h82;
    localparam logic [7:0] LEN_SHORT_MAX = 8'h7F;
    localparam logic [7:0] VERSION_TAG   = 8'hA0;
    localparam logic [2:0] VERSION_SKIP  = 3'd4;

    typedef enum logic [3:0] {
        PH_OUTER   = 4'd0,
        PH_TBS     = 4'd1,
        PH_VERSION = 4'd2,
        PH_VSKIP   = 4'd3,
        PH_SERIAL  = 4'd4,
        PH_SIG     = 4'd5,
        PH_ISSUER  = 4'd6,
        PH_VALID   = 4'd7,
        PH_SUBJECT = 4'd8,
        PH_DONE    = 4'd9,
        PH_ERR     = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        HS_TAG     = 2'd0,
        HS_LEN     = 2'd1,
        HS_LENB    = 2'd2,
        HS_CONTENT = 2'd3
    } t_hstep;

    typedef struct packed {
        logic [7:0] cert_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  out_byte;
        logic [15:0] serial_length;
        logic [15:0] issuer_length;
        logic [15:0] subject_length;
        logic [1:0]  status;
        logic        run_end;
    } t_out_item;

    // One queue entry holds everything a single input word causes.
    typedef struct packed {
        logic        has_byte;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        has_sum;
        logic [15:0] serial_len;
        logic [15:0] issuer_len;
        logic [15:0] subject_len;
        logic [1:0]  status;
    } t_entry;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

endpackage
`default_nettype wire

FILE: rtl/core/xdfl_front.sv
// Front end: configuration registers and the DER header parser.
// Classifies each input word into a queue entry; uses xdfl_pkg.
`default_nettype none
module xdfl_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [xdfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [xdfl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                         i_in_valid,
    input  wire xdfl_pkg::t_in_item           i_in_item,
    input  wire logic                         i_q_full,
    output logic                              o_in_ready,
    output logic                              o_push,
    output xdfl_pkg::t_entry                  o_entry
);
    import xdfl_pkg::*;

    logic [15:0] r_serial_cap, r_issuer_cap, r_subject_cap;
    logic        r_lengths_only;

    t_phase      r_phase, n_phase;
    t_hstep      r_hstep, n_hstep;
    logic [1:0]  r_lbl, n_lbl;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_cr, n_cr;
    logic [2:0]  r_vskip, n_vskip;
    logic [15:0] r_serial, n_serial;
    logic [15:0] r_issuer, n_issuer;
    logic [15:0] r_subject, n_subject;
    logic [1:0]  r_err, n_err;

    // Post-step values before the rearm on the final word.
    t_phase      s_phase;
    t_hstep      s_hstep;
    logic [15:0] s_serial, s_issuer, s_subject;
    logic [1:0]  s_err;

    logic        accept;
    logic [7:0]  b;
    t_phase      ep;
    t_hstep      eh;
    logic        elem;
    logic        hd;
    logic [15:0] hd_len;
    logic [15:0] acc2;
    logic [1:0]  lbl_dec;
    logic [2:0]  vskip_dec;
    logic [15:0] cr_dec;
    logic        kind_ok;
    logic [1:0]  kind;

    function automatic t_phase f_next_phase(input t_phase p);
        t_phase r;
        unique case (p)
            PH_SERIAL:  r = PH_SIG;
            PH_SIG:     r = PH_ISSUER;
            PH_ISSUER:  r = PH_VALID;
            PH_VALID:   r = PH_SUBJECT;
            PH_SUBJECT: r = PH_DONE;
            default:    r = PH_DONE;
        endcase
        return r;
    endfunction

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !i_q_full;
    assign b          = i_in_item.cert_byte;
    assign acc2       = {r_acc[7:0], b};
    assign lbl_dec    = r_lbl - 2'd1;
    assign vskip_dec  = r_vskip - 3'd1;
    assign cr_dec     = r_cr - 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serial_cap   <= 16'hFFFF;
            r_issuer_cap   <= 16'hFFFF;
            r_subject_cap  <= 16'hFFFF;
            r_lengths_only <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SERIAL_CAP:   r_serial_cap   <= i_cfg_data;
                CFG_ISSUER_CAP:   r_issuer_cap   <= i_cfg_data;
                CFG_SUBJECT_CAP:  r_subject_cap  <= i_cfg_data;
                CFG_LENGTHS_ONLY: r_lengths_only <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Next-state logic of the parser.
    always_comb begin
        s_phase   = r_phase;
        s_hstep   = r_hstep;
        n_lbl     = r_lbl;
        n_acc     = r_acc;
        n_cr      = r_cr;
        n_vskip   = r_vskip;
        s_serial  = r_serial;
        s_issuer  = r_issuer;
        s_subject = r_subject;
        s_err     = r_err;
        hd        = 1'b0;
        hd_len    = 16'd0;

        // The version check hands a non-version byte straight to the serial header.
        ep   = (r_phase == PH_VERSION) ? PH_SERIAL : r_phase;
        eh   = (r_phase == PH_VERSION) ? HS_TAG : r_hstep;
        elem = 1'b0;

        unique case (r_phase)
            PH_VERSION: begin
                if (b == VERSION_TAG) begin
                    n_vskip = VERSION_SKIP;
                    s_phase = PH_VSKIP;
                end else begin
                    elem = 1'b1;
                end
            end
            PH_VSKIP: begin
                n_vskip = vskip_dec;
                if (vskip_dec == 3'd0) begin
                    s_phase = PH_SERIAL;
                    s_hstep = HS_TAG;
                end
            end
            PH_OUTER, PH_TBS, PH_SERIAL, PH_SIG, PH_ISSUER, PH_VALID, PH_SUBJECT: begin
                elem = 1'b1;
            end
            default: ;
        endcase

        if (elem) begin
            s_phase = ep;
            s_hstep = eh;
            if (eh != HS_CONTENT) begin
                if (ep == PH_ISSUER)
                    s_issuer = r_issuer + 16'd1;
                else if (ep == PH_SUBJECT)
                    s_subject = r_subject + 16'd1;
            end
            unique case (eh)
                HS_TAG: begin
                    if ((b & TAG_HIGH_MASK) == TAG_HIGH_MASK) begin
                        s_phase = PH_ERR;
                        s_err   = ST_HEADER;
                        s_hstep = HS_TAG;
                    end else begin
                        s_hstep = HS_LEN;
                    end
                end
                HS_LEN: begin
                    if (b == LEN_INDEF || b > LEN_LONG_MAX) begin
                        s_phase = PH_ERR;
                        s_err   = ST_HEADER;
                        s_hstep = HS_TAG;
                    end else if (b <= LEN_SHORT_MAX) begin
                        hd     = 1'b1;
                        hd_len = {8'd0, b};
                    end else begin
                        n_lbl   = b[1:0];
                        n_acc   = 16'd0;
                        s_hstep = HS_LENB;
                    end
                end
                HS_LENB: begin
                    n_acc = acc2;
                    n_lbl = lbl_dec;
                    if (lbl_dec == 2'd0) begin
                        hd     = 1'b1;
                        hd_len = acc2;
                    end
                end
                HS_CONTENT: begin
                    n_cr = cr_dec;
                    if (cr_dec == 16'd0) begin
                        s_hstep = HS_TAG;
                        s_phase = f_next_phase(ep);
                    end
                end
                default: ;
            endcase

            if (hd) begin
                if (ep == PH_OUTER) begin
                    s_phase = PH_TBS;
                    s_hstep = HS_TAG;
                end else if (ep == PH_TBS) begin
                    s_phase = PH_VERSION;
                    s_hstep = HS_TAG;
                end else begin
                    if (ep == PH_SERIAL)
                        s_serial = hd_len;
                    else if (ep == PH_ISSUER)
                        s_issuer = s_issuer + hd_len;
                    else if (ep == PH_SUBJECT)
                        s_subject = s_subject + hd_len;
                    if (hd_len == 16'd0) begin
                        s_hstep = HS_TAG;
                        s_phase = f_next_phase(ep);
                    end else begin
                        n_cr    = hd_len;
                        s_hstep = HS_CONTENT;
                    end
                end
            end
        end

        n_phase   = s_phase;
        n_hstep   = s_hstep;
        n_serial  = s_serial;
        n_issuer  = s_issuer;
        n_subject = s_subject;
        n_err     = s_err;
        // The final word rearms the parser for the next certificate.
        if (i_in_item.final_byte) begin
            n_phase   = PH_OUTER;
            n_hstep   = HS_TAG;
            n_lbl     = 2'd0;
            n_acc     = 16'd0;
            n_cr      = 16'd0;
            n_vskip   = 3'd0;
            n_serial  = 16'd0;
            n_issuer  = 16'd0;
            n_subject = 16'd0;
            n_err     = ST_OK;
        end
    end

    // Output logic: the queue entry for this word.
    always_comb begin
        kind_ok = 1'b1;
        kind    = KIND_SERIAL;
        if (r_phase == PH_SERIAL && r_hstep == HS_CONTENT)
            kind = KIND_SERIAL;
        else if (r_phase == PH_ISSUER)
            kind = KIND_ISSUER;
        else if (r_phase == PH_SUBJECT)
            kind = KIND_SUBJECT;
        else
            kind_ok = 1'b0;

        o_entry.has_byte    = kind_ok && (s_err == ST_OK) && !r_lengths_only;
        o_entry.kind        = kind;
        o_entry.data        = b;
        o_entry.has_sum     = i_in_item.final_byte;
        o_entry.serial_len  = s_serial;
        o_entry.issuer_len  = s_issuer;
        o_entry.subject_len = s_subject;
        if (s_err != ST_OK)
            o_entry.status = s_err;
        else if (s_phase != PH_DONE)
            o_entry.status = ST_TRUNCATED;
        else if (!r_lengths_only && (s_serial > r_serial_cap ||
                 s_issuer > r_issuer_cap || s_subject > r_subject_cap))
            o_entry.status = ST_CAPACITY;
        else
            o_entry.status = ST_OK;

        o_push = accept && (o_entry.has_byte || o_entry.has_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OUTER;
            r_hstep   <= HS_TAG;
            r_lbl     <= 2'd0;
            r_acc     <= 16'd0;
            r_cr      <= 16'd0;
            r_vskip   <= 3'd0;
            r_serial  <= 16'd0;
            r_issuer  <= 16'd0;
            r_subject <= 16'd0;
            r_err     <= ST_OK;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_hstep   <= n_hstep;
            r_lbl     <= n_lbl;
            r_acc     <= n_acc;
            r_cr      <= n_cr;
            r_vskip   <= n_vskip;
            r_serial  <= n_serial;
            r_issuer  <= n_issuer;
            r_subject <= n_subject;
            r_err     <= n_err;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/xdfl_queue.sv
// Short first-in first-out queue of parsed entries between front and back.
// Register based; uses xdfl_pkg for the entry type.
`default_nettype none
module xdfl_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire xdfl_pkg::t_q_ctrl i_ctrl,
    input  wire xdfl_pkg::t_entry  i_entry,
    output xdfl_pkg::t_q_stat      o_stat,
    output xdfl_pkg::t_entry       o_entry
);
    import xdfl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_entry            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign o_entry      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push)
            r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_ctrl.push)
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PTR_W'(1);
            if (i_ctrl.pop)
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PTR_W'(1);
            if (i_ctrl.push && !i_ctrl.pop)
                r_count <= r_count + CNT_W'(1);
            else if (!i_ctrl.push && i_ctrl.pop)
                r_count <= r_count - CNT_W'(1);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_ctrl.push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stat.valid |-> !i_ctrl.pop)
        else $error("pop from empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.push && !i_ctrl.pop) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("queue count did not advance on push");

endmodule
`default_nettype wire

FILE: rtl/core/xdfl_back.sv
// Back end: expands each queue entry into one or two output words.
// Holds the entry being delivered; uses xdfl_pkg.
`default_nettype none
module xdfl_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire xdfl_pkg::t_q_stat i_q_stat,
    input  wire xdfl_pkg::t_entry  i_entry,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output xdfl_pkg::t_out_item    o_out_item
);
    import xdfl_pkg::*;

    t_entry r_hold;
    logic   r_hb, r_hs;
    logic   fire;
    logic   drained;

    assign o_out_valid = r_hb || r_hs;
    assign fire        = o_out_valid && i_out_ready;
    // The hold register frees up when its last pending word is taken.
    assign drained     = !o_out_valid || (fire && !(r_hb && r_hs));
    assign o_pop       = drained && i_q_stat.valid;

    always_comb begin
        if (r_hb) begin
            o_out_item.item_kind      = r_hold.kind;
            o_out_item.out_byte       = r_hold.data;
            o_out_item.serial_length  = 16'd0;
            o_out_item.issuer_length  = 16'd0;
            o_out_item.subject_length = 16'd0;
            o_out_item.status         = ST_OK;
            o_out_item.run_end        = !r_hs;
        end else begin
            o_out_item.item_kind      = KIND_SUMMARY;
            o_out_item.out_byte       = 8'd0;
            o_out_item.serial_length  = r_hold.serial_len;
            o_out_item.issuer_length  = r_hold.issuer_len;
            o_out_item.subject_length = r_hold.subject_len;
            o_out_item.status         = r_hold.status;
            o_out_item.run_end        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_hold <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb <= 1'b0;
            r_hs <= 1'b0;
        end else if (o_pop) begin
            r_hb <= i_entry.has_byte;
            r_hs <= i_entry.has_sum;
        end else if (drained) begin
            r_hb <= 1'b0;
            r_hs <= 1'b0;
        end else if (fire) begin
            r_hb <= 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/x509_der_field_locator_top.sv
// Throughput: one certificate byte accepted every cycle while the entry queue is not
// full; a final byte that also carries a located byte costs an extra output word for its summary.
// A result word is registered in the entry queue and then in the back-end hold register before it is offered.
// The entry queue between parser and output stage sets the burst slack.
// Reset (synchronous, active low) rearms the parser, empties the queue and
// returns the capacity and mode registers to their reset values.
// Top level: wires the parser front end, the entry queue and the back end.
// Depends on xdfl_pkg, xdfl_front, xdfl_queue and xdfl_back.
`default_nettype none
module x509_der_field_locator_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [xdfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [xdfl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire xdfl_pkg::t_in_item              i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output xdfl_pkg::t_out_item                  o_out_item
);
    import xdfl_pkg::*;

    t_q_stat q_stat;
    t_q_ctrl q_ctrl;
    t_entry  push_entry;
    t_entry  head_entry;
    logic    push;
    logic    pop;

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    xdfl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_q_full    (q_stat.full),
        .o_in_ready  (o_in_ready),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    xdfl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_entry (push_entry),
        .o_stat  (q_stat),
        .o_entry (head_entry)
    );

    xdfl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_entry     (head_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire
